@@ src/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared codes, defaults and cell command type for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  // default sizes
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 8;

  // field widths fixed by the interface
  localparam int OP_WIDTH  = 3;
  localparam int ERR_WIDTH = 2;

  // operation codes
  localparam logic [OP_WIDTH-1:0] OP_NOP        = 3'd0;
  localparam logic [OP_WIDTH-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_WIDTH-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OP_WIDTH-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_WIDTH-1:0] OP_POP_BACK   = 3'd4;
  localparam logic [OP_WIDTH-1:0] OP_CLEAR      = 3'd5;

  // error codes
  localparam logic [ERR_WIDTH-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_WIDTH-1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [ERR_WIDTH-1:0] ERR_OVERFLOW  = 2'd2;

  // command broadcast to every cell of a chain
  typedef struct packed {
    logic ins;  // shift toward higher index, new value enters cell 0
    logic del;  // shift toward lower index, cell 0 drops out
    logic wr;   // write new value into the cell at the fill position
  } cell_cmd_t;

endpackage

@@ src/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque built from two chains of cells, one result per operation.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries operations: opcode (no-op, push back, push front, pop front,
//   pop back, clear) and a value used by the pushes. m_* returns one
//   transaction per operation: front and back value, count, empty flag and
//   error code, all as seen after the operation.
//   Two cell chains hold the elements: the front chain keeps the front in
//   cell zero, the back chain keeps the back in cell zero. A push at one end
//   shifts that end's chain and writes the other chain at the fill position;
//   a pop shifts one chain and lowers the count.
//   The result is valid in the cycle after the operation is accepted, and one
//   operation per cycle is taken while m_tready stays high, since the cell
//   chains and the count register are both updated on each accepted operation.
//   A result waits in place while m_tready is low; s_tready then drops and
//   the queue state holds until the result is taken.
//   Reset empties the queue and drops any pending result. A pop on an empty
//   queue reports underflow, a push on a full queue reports overflow; both
//   leave the state unchanged. Values read zero while the queue is empty.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  localparam int CNT_WIDTH = $clog2(DEPTH + 1),
  localparam int IN_BITS   = deq_pkg::OP_WIDTH + DATA_WIDTH,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 2 * DATA_WIDTH + CNT_WIDTH + 1 + deq_pkg::ERR_WIDTH,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // opcode, value
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // front_value, back_value, count, empty_res, error
);
  import deq_pkg::*;

  logic [OP_WIDTH-1:0]   opcode;
  logic [DATA_WIDTH-1:0] value;
  logic                  accept;
  logic                  full;
  logic                  empty;

  logic [CNT_WIDTH-1:0]  count;
  logic [CNT_WIDTH-1:0]  count_next;
  logic [ERR_WIDTH-1:0]  error;
  logic [ERR_WIDTH-1:0]  error_next;

  cell_cmd_t             front_cmd;
  cell_cmd_t             back_cmd;
  logic [DATA_WIDTH-1:0] front_head;
  logic [DATA_WIDTH-1:0] back_head;
  logic [DATA_WIDTH-1:0] front_value;
  logic [DATA_WIDTH-1:0] back_value;
  logic                  empty_res;

  // input unpacking
  assign opcode = s_tdata[OP_WIDTH-1:0];
  assign value  = s_tdata[IN_BITS-1:OP_WIDTH];

  // take a new operation when no result is held back
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign full  = (count == CNT_WIDTH'(DEPTH));
  assign empty = (count == '0);

  // operation decode into chain commands, count and error
  always_comb begin
    front_cmd  = '0;
    back_cmd   = '0;
    count_next = count;
    error_next = ERR_OK;
    unique case (opcode)
      OP_PUSH_BACK: begin
        if (full) begin
          error_next = ERR_OVERFLOW;
        end else begin
          front_cmd.wr = 1'b1;
          back_cmd.ins = 1'b1;
          count_next   = count + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          error_next = ERR_OVERFLOW;
        end else begin
          front_cmd.ins = 1'b1;
          back_cmd.wr   = 1'b1;
          count_next    = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          error_next = ERR_UNDERFLOW;
        end else begin
          front_cmd.del = 1'b1;
          count_next    = count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          error_next = ERR_UNDERFLOW;
        end else begin
          back_cmd.del = 1'b1;
          count_next   = count - 1'b1;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
    if (!accept) begin
      front_cmd = '0;
      back_cmd  = '0;
    end
  end

  // count, error and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      error    <= ERR_OK;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        error    <= error_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // front chain: front element in cell zero
  deq_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_WIDTH  (CNT_WIDTH)
  ) u_front (
    .clk   (clk),
    .cmd   (front_cmd),
    .fill  (count),
    .value (value),
    .head  (front_head)
  );

  // back chain: back element in cell zero
  deq_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_WIDTH  (CNT_WIDTH)
  ) u_back (
    .clk   (clk),
    .cmd   (back_cmd),
    .fill  (count),
    .value (value),
    .head  (back_head)
  );

  // result fields from the state left by the last operation
  assign empty_res   = (count == '0);
  assign front_value = empty_res ? '0 : front_head;
  assign back_value  = empty_res ? '0 : back_head;

  assign m_tdata = OUT_W'({error, empty_res, count, back_value, front_value});

endmodule

@@ src/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of a chain: shifts with its neighbors or takes a write.
// ----------------------------------------------------------------------------
module deq_cell #(
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int CNT_WIDTH  = 5,
  parameter int IDX        = 0
) (
  input  logic                   clk,
  input  deq_pkg::cell_cmd_t     cmd,
  input  logic [CNT_WIDTH-1:0]   fill,
  input  logic [DATA_WIDTH-1:0]  value,
  input  logic [DATA_WIDTH-1:0]  prev_data,
  input  logic [DATA_WIDTH-1:0]  next_data,
  output logic [DATA_WIDTH-1:0]  data
);
  import deq_pkg::*;

  logic at_fill;

  // this cell sits just past the last stored element
  assign at_fill = (fill == CNT_WIDTH'(IDX));

  // shift or write update, payload needs no reset
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      data <= prev_data;
    end else if (cmd.del) begin
      data <= next_data;
    end else if (cmd.wr && at_fill) begin
      data <= value;
    end
  end

endmodule

@@ src/deq_chain.sv @@
// ----------------------------------------------------------------------------
// deq_chain
// Row of cells holding the queue in order, element zero at cell zero.
// ----------------------------------------------------------------------------
module deq_chain #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int CNT_WIDTH  = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  deq_pkg::cell_cmd_t     cmd,
  input  logic [CNT_WIDTH-1:0]   fill,
  input  logic [DATA_WIDTH-1:0]  value,
  output logic [DATA_WIDTH-1:0]  head
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  // cells wired to their neighbors, new value enters at cell zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_d;
    logic [DATA_WIDTH-1:0] next_d;

    if (i == 0) begin : g_first
      assign prev_d = value;
    end else begin : g_mid_prev
      assign prev_d = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_d = cell_data[i];
    end else begin : g_mid_next
      assign next_d = cell_data[i+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_WIDTH  (CNT_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .fill      (fill),
      .value     (value),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i])
    );
  end

  assign head = cell_data[0];

endmodule

@@ src/deq_checker.sv @@
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  localparam int CNT_WIDTH = $clog2(DEPTH + 1),
  localparam int IN_BITS   = deq_pkg::OP_WIDTH + DATA_WIDTH,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 2 * DATA_WIDTH + CNT_WIDTH + 1 + deq_pkg::ERR_WIDTH,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,   // opcode, value
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata    // front_value, back_value, count, empty_res, error
);
  import deq_pkg::*;

  localparam int CNT_LO = 2 * DATA_WIDTH;
  localparam int EMP_POS = CNT_LO + CNT_WIDTH;
  localparam int ERR_LO = EMP_POS + 1;

  logic [DATA_WIDTH-1:0] front_value;
  logic [DATA_WIDTH-1:0] back_value;
  logic [CNT_WIDTH-1:0]  count;
  logic                  empty_res;
  logic [ERR_WIDTH-1:0]  error;

  // result fields
  assign front_value = m_tdata[DATA_WIDTH-1:0];
  assign back_value  = m_tdata[CNT_LO-1:DATA_WIDTH];
  assign count       = m_tdata[EMP_POS-1:CNT_LO];
  assign empty_res   = m_tdata[EMP_POS];
  assign error       = m_tdata[ERR_LO+ERR_WIDTH-1:ERR_LO];

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // empty flag tracks count
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (empty_res == (count == '0)))
    else $error("empty flag disagrees with count");

  // empty queue shows zero values
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && empty_res |-> front_value == '0 && back_value == '0)
    else $error("nonzero value from empty queue");

  // count bounded and error code defined
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> count <= CNT_WIDTH'(DEPTH) &&
                 (error == ERR_OK || error == ERR_UNDERFLOW || error == ERR_OVERFLOW))
    else $error("count or error out of range");

endmodule

bind double_ended_queue deq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (.*);

@@ tb/double_ended_queue_checker.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// Watches both stream channels of the deque, tracks its contents and checks
// every result transaction field by field against the predicted deque status.
// ----------------------------------------------------------------------------
module double_ended_queue_checker
  import deq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // opcode, value
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // front_value, back_value, count, empty_res, error
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          underflows,
  output int          overflows,
  output int          full_hits
);

  localparam int RING_DEPTH = DEPTH_DEF;

  // result layout, highest field first so a cast of m_tdata lines up
  typedef struct packed {
    logic [ERR_WIDTH-1:0] error;
    logic                 empty_res;
    logic [4:0]           count;
    logic [7:0]           back_value;
    logic [7:0]           front_value;
  } deq_status_t;

  // shadow copy of the deque
  logic [7:0]  ring [RING_DEPTH];
  logic [3:0]  head_q;
  logic [3:0]  tail_q;
  logic [4:0]  fill_q;

  deq_status_t status_due [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    underflows   = 0;
    overflows    = 0;
    full_hits    = 0;
  end

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got_v, exp_v);
    fail_count++;
  endtask

  // apply one operation to the shadow deque and return the status after it
  function automatic deq_status_t status_after_op(input logic [OP_WIDTH-1:0] op,
                                                  input logic [7:0] val);
    deq_status_t st;
    logic [ERR_WIDTH-1:0] err;
    logic full_now;
    logic empty_now;
    err       = ERR_OK;
    full_now  = (fill_q == 5'(RING_DEPTH));
    empty_now = (fill_q == 5'd0);
    case (op)
      OP_PUSH_BACK: begin
        if (full_now) begin
          err = ERR_OVERFLOW;
        end else begin
          ring[tail_q] = val;
          tail_q       = tail_q + 4'd1;
          fill_q       = fill_q + 5'd1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full_now) begin
          err = ERR_OVERFLOW;
        end else begin
          head_q       = head_q - 4'd1;
          ring[head_q] = val;
          fill_q       = fill_q + 5'd1;
        end
      end
      OP_POP_FRONT: begin
        if (empty_now) begin
          err = ERR_UNDERFLOW;
        end else begin
          head_q = head_q + 4'd1;
          fill_q = fill_q - 5'd1;
        end
      end
      OP_POP_BACK: begin
        if (empty_now) begin
          err = ERR_UNDERFLOW;
        end else begin
          tail_q = tail_q - 4'd1;
          fill_q = fill_q - 5'd1;
        end
      end
      OP_CLEAR: begin
        head_q = 4'd0;
        tail_q = 4'd0;
        fill_q = 5'd0;
      end
      default: begin
        // no-op and the unused codes leave everything alone
      end
    endcase
    // values read zero on an empty deque
    if (fill_q == 5'd0) begin
      st.front_value = 8'd0;
      st.back_value  = 8'd0;
    end else begin
      st.front_value = ring[head_q];
      st.back_value  = ring[tail_q - 4'd1];
    end
    st.count     = fill_q;
    st.empty_res = (fill_q == 5'd0);
    st.error     = err;
    return st;
  endfunction

  // prediction on accepted operations, comparison on accepted results
  always @(posedge clk) begin
    deq_status_t got;
    deq_status_t want;
    if (rst) begin
      head_q = 4'd0;
      tail_q = 4'd0;
      fill_q = 5'd0;
      for (int i = 0; i < RING_DEPTH; i++) ring[i] = 8'd0;
      status_due.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        status_due.push_back(status_after_op(s_tdata[2:0], s_tdata[10:3]));
      end
      if (m_tvalid && m_tready) begin
        got = deq_status_t'(m_tdata);
        results_seen++;
        if (status_due.size() == 0) begin
          report_mismatch("result with no operation pending, count", got.count, 0);
        end else begin
          want = status_due.pop_front();
          if (want.error == ERR_UNDERFLOW) underflows++;
          if (want.error == ERR_OVERFLOW) overflows++;
          if (want.count == 5'(RING_DEPTH)) full_hits++;
          if (got.front_value !== want.front_value)
            report_mismatch("front_value", got.front_value, want.front_value);
          if (got.back_value !== want.back_value)
            report_mismatch("back_value", got.back_value, want.back_value);
          if (got.count !== want.count)
            report_mismatch("count", got.count, want.count);
          if (got.empty_res !== want.empty_res)
            report_mismatch("empty_res", got.empty_res, want.empty_res);
          if (got.error !== want.error)
            report_mismatch("error", got.error, want.error);
        end
      end
    end
    pending = status_due.size();
  end

endmodule

@@ tb/double_ended_queue_tb.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Drives operations into the deque with directed corner cases followed by
// biased random traffic that fills and drains it, under varying back-pressure.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import deq_pkg::*;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // opcode, value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // front_value, back_value, count, empty_res, error

  int fail_count;
  int pending;
  int results_seen;
  int underflows;
  int overflows;
  int full_hits;

  // idle percentages of the two sides
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;

  // random traffic bias: percent of pushes and items left in this stretch
  int push_pct;
  int stretch_left = 0;
  int ops_sent     = 0;

  double_ended_queue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  double_ended_queue_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .underflows   (underflows),
    .overflows    (overflows),
    .full_hits    (full_hits)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // one operation transaction, with random idle cycles ahead of it
  task automatic send_op(input logic [OP_WIDTH-1:0] op, input logic [7:0] val);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, val, op};
    do @(posedge clk); while (!s_tready);
    ops_sent++;
  endtask

  // corner cases: empty pops, unused codes, fill to full, overflow at both ends, pops, clear
  task automatic run_directed();
    send_op(OP_NOP, 8'hff);
    send_op(OP_POP_FRONT, 8'h00);
    send_op(OP_POP_BACK, 8'hff);
    send_op(3'd6, 8'h5a);
    send_op(3'd7, 8'ha5);
    send_op(OP_PUSH_BACK, 8'hff);
    send_op(OP_PUSH_FRONT, 8'h00);
    for (int i = 0; i < 14; i++) begin
      send_op((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, 8'(8'h11 * i + 8'h5a));
    end
    send_op(OP_PUSH_BACK, 8'ha5);
    send_op(OP_PUSH_FRONT, 8'h5a);
    send_op(OP_POP_FRONT, 8'h00);
    send_op(OP_POP_BACK, 8'h00);
    send_op(OP_CLEAR, 8'hff);
  endtask

  // biased random operation: long push-heavy, pop-heavy or balanced stretches
  task automatic send_random_op();
    int r;
    logic [OP_WIDTH-1:0] op;
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(10, 40);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
    end
    stretch_left--;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      op = OP_CLEAR;
    end else if (r < 5) begin
      op = OP_NOP;
    end else if (r < 7) begin
      op = ($urandom_range(0, 1) != 0) ? 3'd7 : 3'd6;
    end else if ($urandom_range(0, 99) < push_pct) begin
      op = ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end else begin
      op = ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
    end
    send_op(op, 8'($urandom_range(0, 255)));
  endtask

  // stimulus and verdict
  initial begin
    int drain_wait;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 10;
          sink_idle_pct = 71;
        end
        1: begin
          src_idle_pct  = 71;
          sink_idle_pct = 10;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      if (phase == 0) run_directed();
      for (int i = 0; i < 160; i++) send_random_op();
    end
    s_tvalid <= 1'b0;
    drain_wait = 0;
    while (pending != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (10) @(posedge clk);
    if (pending != 0) begin
      $display("ERROR: %0d results never arrived", pending);
    end
    $display("Sent %0d operations and checked %0d results", ops_sent, results_seen);
    $display("Saw %0d underflow, %0d overflow and %0d full-deque results",
             underflows, overflows, full_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("ERROR: run limit reached");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/deq_pkg.sv
src/deq_cell.sv
src/deq_chain.sv
src/double_ended_queue.sv
src/deq_checker.sv
tb/double_ended_queue_checker.sv
tb/double_ended_queue_tb.sv
